>>> hdl/qte_pkg.sv
package qte_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STEPS  = 16;
    localparam int MAX_STEPS     = 24;

    localparam int PW      = (2 * FRACTION_BITS + 2 > 36) ? 2 * FRACTION_BITS + 2 : 36;
    localparam int VW      = 34;
    localparam int AW      = 32;
    localparam int TW      = 32;
    localparam int SQ_BITS = 31;
    localparam int RW      = 63;
    localparam int OW      = 16;
    localparam int TSH_L   = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;
    localparam int TSH_R   = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;

    localparam logic signed [PW-1:0] ONE = PW'(1) << (2 * FRACTION_BITS);
    localparam logic [RW-1:0] RAD_FULL = RW'(1) << 60;
    localparam logic [AW-1:0] ANG_POS_HALF_PI = 32'h4000_0000;
    localparam logic [AW-1:0] ANG_NEG_HALF_PI = 32'hC000_0000;
    localparam logic [AW-1:0] ANG_ROUND = 32'h0000_8000;

    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [AW-1:0]        z;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic [RW-1:0]      rem;
        logic [SQ_BITS-1:0] root;
    } t_sq;

    typedef struct packed {
        t_vec                 yaw;
        t_vec                 roll;
        logic signed [TW-1:0] t;
        logic                 sat;
    } t_side;

    function automatic logic [AW-1:0] atan_lut(input int i);
        logic [AW-1:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10680094;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Scales the vector below 2^30 and turns a left half-plane vector into the right one.
    function automatic t_vec vec_init(input t_prod a, input t_prod b);
        logic [PW-1:0] ma;
        logic [PW-1:0] mb;
        logic [PW-1:0] m;
        int            sh;
        t_prod         ys;
        t_prod         xs;
        t_vec          v;
        ma = a[PW-1] ? PW'(-a) : PW'(a);
        mb = b[PW-1] ? PW'(-b) : PW'(b);
        m  = (ma > mb) ? ma : mb;
        sh = 0;
        for (int s = PW - 30; s >= 0; s--) begin
            if ((m >> s) < (PW'(1) << 30)) begin
                sh = s;
            end
        end
        ys     = a >>> sh;
        xs     = b >>> sh;
        v.zero = (m == '0);
        v.z    = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                v.x = VW'(ys);
                v.y = VW'(-xs);
                v.z = ANG_POS_HALF_PI;
            end else begin
                v.x = VW'(-ys);
                v.y = VW'(xs);
                v.z = ANG_NEG_HALF_PI;
            end
        end else begin
            v.x = VW'(xs);
            v.y = VW'(ys);
        end
        return v;
    endfunction

    function automatic logic signed [OW-1:0] to_bam(input t_vec v);
        logic [AW-1:0] s;
        s = (v.zero ? '0 : v.z) + ANG_ROUND;
        return s[AW-1:AW-OW];
    endfunction

endpackage

>>> hdl/qte_in_if.sv
interface qte_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    modport source(output valid, q_w, q_x, q_y, q_z, input ready);
    modport sink(input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

>>> hdl/qte_out_if.sv
interface qte_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] roll_out;
    logic               pitch_saturated;
    modport source(output valid, yaw_out, pitch_out, roll_out, pitch_saturated, input ready);
    modport sink(input valid, yaw_out, pitch_out, roll_out, pitch_saturated, output ready);
endinterface

>>> hdl/qte_sqrt_cell.sv
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  qte_pkg::t_sq i_sq,
    output qte_pkg::t_sq o_sq
);

    qte_pkg::t_sq                r_sq;
    qte_pkg::t_sq                n_sq;
    logic [qte_pkg::RW-1:0]      term;

    always_comb begin
        term = (qte_pkg::RW'(i_sq.root) << (K + 1)) + (qte_pkg::RW'(1) << (2 * K));
        n_sq = i_sq;
        if (i_sq.rem >= term) begin
            n_sq.rem  = i_sq.rem - term;
            n_sq.root = i_sq.root | (qte_pkg::SQ_BITS'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

>>> hdl/qte_cordic_cell.sv
module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_vec i_vec,
    output qte_pkg::t_vec o_vec
);

    qte_pkg::t_vec                r_vec;
    qte_pkg::t_vec                n_vec;
    logic signed [qte_pkg::VW-1:0] dx;
    logic signed [qte_pkg::VW-1:0] dy;

    always_comb begin
        dx    = i_vec.y >>> STEP;
        dy    = i_vec.x >>> STEP;
        n_vec = i_vec;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + qte_pkg::atan_lut(STEP);
        end else begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - qte_pkg::atan_lut(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

>>> hdl/quaternion_to_euler_angles.sv
// Converts one attitude quaternion per beat into Z-Y-X Euler angles (yaw, pitch, roll) as
// 16-bit binary angles, and accepts a new beat every clock unless the output stalls. The
// stages are the product register, the clamp and square register, 31 bit-per-cycle square
// root cells, the pitch vector scaling register, one CORDIC cell per step and the output
// register. The pipeline stalls as a whole while a result waits to be taken.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    qte_in_if.sink   i_quat,
    qte_out_if.source o_angle
);

    localparam int NCELL = (CORDIC_STEPS < qte_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                                : qte_pkg::MAX_STEPS;
    localparam int SQ    = qte_pkg::SQ_BITS;
    localparam int DEPTH = 3 + SQ + NCELL;

    logic en;

    logic signed [31:0] p_wz, p_xy, p_ww, p_xx, p_wx, p_yz, p_zz, p_wy, p_xz;
    qte_pkg::t_prod r_ya, r_xa, r_yr, r_xr, r_sp;

    qte_pkg::t_prod                   sp_c;
    logic                             sat;
    logic signed [qte_pkg::TW-1:0]    t_val;
    logic [SQ-1:0]                    t_mag;
    logic [2*SQ-1:0]                  t_sq2;
    qte_pkg::t_side                   r_side;
    qte_pkg::t_sq                     r_sq0;
    qte_pkg::t_side                   r_sdly [SQ];
    qte_pkg::t_sq                     sq [SQ+1];

    qte_pkg::t_vec yv [NCELL+1];
    qte_pkg::t_vec pv [NCELL+1];
    qte_pkg::t_vec rv [NCELL+1];
    logic          r_sat_dly [NCELL];
    logic          r_csat;

    logic [DEPTH-1:0] r_vld;
    logic             r_out_vld;
    logic signed [15:0] r_yaw, r_pitch, r_roll;
    logic             r_psat;

    assign en           = !r_out_vld || o_angle.ready;
    assign i_quat.ready = en;

    assign p_wz = 32'(i_quat.q_w) * 32'(i_quat.q_z);
    assign p_xy = 32'(i_quat.q_x) * 32'(i_quat.q_y);
    assign p_ww = 32'(i_quat.q_w) * 32'(i_quat.q_w);
    assign p_xx = 32'(i_quat.q_x) * 32'(i_quat.q_x);
    assign p_wx = 32'(i_quat.q_w) * 32'(i_quat.q_x);
    assign p_yz = 32'(i_quat.q_y) * 32'(i_quat.q_z);
    assign p_zz = 32'(i_quat.q_z) * 32'(i_quat.q_z);
    assign p_wy = 32'(i_quat.q_w) * 32'(i_quat.q_y);
    assign p_xz = 32'(i_quat.q_x) * 32'(i_quat.q_z);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ya <= (qte_pkg::PW'(p_wz) + qte_pkg::PW'(p_xy)) <<< 1;
            r_xa <= ((qte_pkg::PW'(p_ww) + qte_pkg::PW'(p_xx)) <<< 1) - qte_pkg::ONE;
            r_yr <= (qte_pkg::PW'(p_wx) + qte_pkg::PW'(p_yz)) <<< 1;
            r_xr <= ((qte_pkg::PW'(p_ww) + qte_pkg::PW'(p_zz)) <<< 1) - qte_pkg::ONE;
            r_sp <= (qte_pkg::PW'(p_wy) - qte_pkg::PW'(p_xz)) <<< 1;
        end
    end

    always_comb begin
        sat  = 1'b0;
        sp_c = r_sp;
        if (r_sp > qte_pkg::ONE) begin
            sp_c = qte_pkg::ONE;
            sat  = 1'b1;
        end else if (r_sp < -qte_pkg::ONE) begin
            sp_c = -qte_pkg::ONE;
            sat  = 1'b1;
        end
        t_val = qte_pkg::TW'((sp_c <<< qte_pkg::TSH_L) >>> qte_pkg::TSH_R);
        t_mag = t_val[qte_pkg::TW-1] ? SQ'(-t_val) : SQ'(t_val);
        t_sq2 = t_mag * t_mag;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side.yaw  <= qte_pkg::vec_init(r_ya, r_xa);
            r_side.roll <= qte_pkg::vec_init(r_yr, r_xr);
            r_side.t    <= t_val;
            r_side.sat  <= sat;
            r_sq0.root  <= '0;
            r_sq0.rem   <= (qte_pkg::RW'(t_sq2) >= qte_pkg::RAD_FULL) ? '0
                           : qte_pkg::RAD_FULL - qte_pkg::RW'(t_sq2);
        end
    end

    assign sq[0] = r_sq0;

    genvar g;
    for (g = 0; g < SQ; g++) begin : g_sqrt
        qte_sqrt_cell #(.K(SQ - 1 - g)) u_cell (
            .i_clk(i_clk),
            .i_en (en),
            .i_sq (sq[g]),
            .o_sq (sq[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sdly[g] <= (g == 0) ? r_side : r_sdly[(g == 0) ? 0 : g - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            yv[0]  <= r_sdly[SQ-1].yaw;
            rv[0]  <= r_sdly[SQ-1].roll;
            pv[0]  <= qte_pkg::vec_init(qte_pkg::PW'(r_sdly[SQ-1].t),
                                        qte_pkg::PW'(sq[SQ].root));
            r_csat <= r_sdly[SQ-1].sat;
        end
    end

    for (g = 0; g < NCELL; g++) begin : g_cordic
        qte_cordic_cell #(.STEP(g)) u_yaw (
            .i_clk(i_clk), .i_en(en), .i_vec(yv[g]), .o_vec(yv[g+1])
        );
        qte_cordic_cell #(.STEP(g)) u_pitch (
            .i_clk(i_clk), .i_en(en), .i_vec(pv[g]), .o_vec(pv[g+1])
        );
        qte_cordic_cell #(.STEP(g)) u_roll (
            .i_clk(i_clk), .i_en(en), .i_vec(rv[g]), .o_vec(rv[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sat_dly[g] <= (g == 0) ? r_csat : r_sat_dly[(g == 0) ? 0 : g - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[DEPTH-2:0], i_quat.valid};
            r_out_vld <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw   <= qte_pkg::to_bam(yv[NCELL]);
            r_pitch <= qte_pkg::to_bam(pv[NCELL]);
            r_roll  <= qte_pkg::to_bam(rv[NCELL]);
            r_psat  <= r_sat_dly[NCELL-1];
        end
    end

    assign o_angle.valid           = r_out_vld;
    assign o_angle.yaw_out         = r_yaw;
    assign o_angle.pitch_out       = r_pitch;
    assign o_angle.roll_out        = r_roll;
    assign o_angle.pitch_saturated = r_psat;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_angle.valid && r_vld == '0)
        else $error("pipeline not cleared by reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle.valid && !o_angle.ready) |-> !i_quat.ready)
        else $error("input taken while output stalled");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle.valid && !o_angle.ready) |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule

>>> verif/tb_quaternion_to_euler_angles.sv
module tb_quaternion_to_euler_angles;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic               sat;
    } angles_t;

    localparam logic [31:0] ARC_STEP [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680094, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    logic i_clk;
    logic i_rst_n;

    qte_in_if  quat_bus ();
    qte_out_if angle_bus ();

    quaternion_to_euler_angles u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_bus),
        .o_angle (angle_bus)
    );

    angles_t pending_angles [$];
    int      cycle_count;
    int      error_count;
    int      beats_sent;
    int      beats_checked;
    int      sat_seen;
    int      burst_left;
    int      stall_mode;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] bam_atan2(input longint y, input longint x);
        longint unsigned m;
        int              s;
        longint          tx;
        longint          dx;
        longint          dy;
        logic [31:0]     z;
        m = (magnitude(y) > magnitude(x)) ? magnitude(y) : magnitude(x);
        if (m == 0) return 32'd0;
        s = 0;
        while ((m >> s) >= (64'd1 << 30)) s++;
        x = x >>> s;
        y = y >>> s;
        z = 32'd0;
        if (x < 0) begin
            tx = x;
            if (y >= 0) begin
                x = y;
                y = -tx;
                z = 32'h4000_0000;
            end else begin
                x = -y;
                y = tx;
                z = 32'hC000_0000;
            end
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] round_bam(input logic [31:0] z);
        logic [31:0] r;
        r = z + 32'h0000_8000;
        return r[31:16];
    endfunction

    function automatic angles_t euler_from_quat(input logic signed [15:0] qw,
                                                input logic signed [15:0] qx,
                                                input logic signed [15:0] qy,
                                                input logic signed [15:0] qz);
        longint          w;
        longint          x;
        longint          y;
        longint          z;
        longint          one;
        longint          sp;
        longint          t;
        longint unsigned t2;
        longint unsigned c;
        angles_t         a;
        w   = qw;
        x   = qx;
        y   = qy;
        z   = qz;
        one = 64'sd1 <<< (2 * qte_pkg::FRACTION_BITS);
        sp  = 2 * (w * y - x * z);
        a.sat = 1'b0;
        if (sp > one) begin
            sp = one;
            a.sat = 1'b1;
        end else if (sp < -one) begin
            sp = -one;
            a.sat = 1'b1;
        end
        if (2 * qte_pkg::FRACTION_BITS >= 30) t = sp >>> (2 * qte_pkg::FRACTION_BITS - 30);
        else t = sp * (64'sd1 <<< (30 - 2 * qte_pkg::FRACTION_BITS));
        t2 = magnitude(t) * magnitude(t);
        c  = floor_sqrt((t2 >= (64'd1 << 60)) ? 64'd0 : (64'd1 << 60) - t2);
        a.yaw   = round_bam(bam_atan2(2 * (w * z + x * y), 2 * (w * w + x * x) - one));
        a.pitch = round_bam(bam_atan2(t, longint'(c)));
        a.roll  = round_bam(bam_atan2(2 * (w * x + y * z), 2 * (w * w + z * z) - one));
        return a;
    endfunction

    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                quat_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        quat_bus.valid <= 1'b1;
        quat_bus.q_w   <= w;
        quat_bus.q_x   <= x;
        quat_bus.q_y   <= y;
        quat_bus.q_z   <= z;
        do @(posedge i_clk); while (!quat_bus.ready);
        pending_angles.push_back(euler_from_quat(w, x, y, z));
        burst_left--;
        beats_sent++;
    endtask

    task automatic drain_results();
        quat_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_angles.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd8192, 16'sd8192, 16'sd0, 16'sd0);
        send_quat(16'sd8192, 16'sd0, 16'sd0, 16'sd8192);
        send_quat(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sd32767, 16'sh8000, 16'sd32767, 16'sh8000);
        send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd1);
        drain_results();
    endtask

    task automatic test_unit_attitudes(input int count);
        real r [4];
        real n;
        for (int k = 0; k < count; k++) begin
            n = 0.0;
            foreach (r[j]) begin
                r[j] = real'($urandom_range(0, 65534)) - 32767.0;
                n = n + r[j] * r[j];
            end
            if (n < 1.0) n = 1.0;
            n = 16384.0 / $sqrt(n);
            send_quat(16'($rtoi(r[0] * n)), 16'($rtoi(r[1] * n)),
                      16'($rtoi(r[2] * n)), 16'($rtoi(r[3] * n)));
        end
    endtask

    task automatic test_gimbal_lock(input int count);
        int a;
        int b;
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(0, 11585);
            b = $urandom_range(0, 11585);
            if ($urandom_range(0, 1) == 1)
                send_quat(16'(a), 16'(-b), 16'(a + int'($urandom_range(0, 60)) - 30),
                          16'(b + int'($urandom_range(0, 60)) - 30));
            else
                send_quat(16'(a), 16'(b), 16'(-a + int'($urandom_range(0, 60)) - 30),
                          16'(b + int'($urandom_range(0, 60)) - 30));
        end
    endtask

    task automatic test_raw_words(input int count);
        for (int k = 0; k < count; k++) begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: angle_bus.ready <= 1'b1;
            1: angle_bus.ready <= ($urandom_range(0, 9) < 7);
            2: angle_bus.ready <= (cycle_count % 5 != 0);
            default: angle_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (i_rst_n && angle_bus.valid && angle_bus.ready) begin
            if (pending_angles.size() == 0) begin
                $error("angle beat with nothing expected");
                error_count++;
            end else begin
                automatic angles_t e = pending_angles.pop_front();
                if (angle_bus.yaw_out !== e.yaw) begin
                    $error("yaw_out expected %0d actual %0d", e.yaw, angle_bus.yaw_out);
                    error_count++;
                end
                if (angle_bus.pitch_out !== e.pitch) begin
                    $error("pitch_out expected %0d actual %0d", e.pitch, angle_bus.pitch_out);
                    error_count++;
                end
                if (angle_bus.roll_out !== e.roll) begin
                    $error("roll_out expected %0d actual %0d", e.roll, angle_bus.roll_out);
                    error_count++;
                end
                if (angle_bus.pitch_saturated !== e.sat) begin
                    $error("pitch_saturated expected %0b actual %0b", e.sat,
                           angle_bus.pitch_saturated);
                    error_count++;
                end
                if (e.sat) sat_seen++;
                beats_checked++;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        sat_seen = 0;
        burst_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        quat_bus.valid = 1'b0;
        quat_bus.q_w = '0;
        quat_bus.q_x = '0;
        quat_bus.q_y = '0;
        quat_bus.q_z = '0;
        angle_bus.ready = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_unit_attitudes(1200);
        drain_results();
        test_gimbal_lock(150);
        test_raw_words(350);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d quaternions and checked %0d angle beats, %0d of them saturated.",
                 beats_sent, beats_checked, sat_seen);
        $display("Covered unit attitudes, gimbal lock, raw 16-bit words and edge values.");
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
